@@ rtl/core/clcs_pkg.sv @@
// Package for the cue list crossfade sampler: sizes, codes, controller/datapath structs.
// No dependencies.
`default_nettype none
package clcs_pkg;
	localparam int MAX_CUES = 16;
	localparam int NUM_CONTROLS = 16;
	localparam int CW = $clog2(MAX_CUES);
	localparam int NW = $clog2(NUM_CONTROLS);
	localparam int MEM_DEPTH = MAX_CUES * NUM_CONTROLS;
	localparam int MW = $clog2(MEM_DEPTH);
	localparam logic [39:0] TIME_LIMIT = 40'd1000000000000;
	localparam logic [24:0] AMT_ONE = 25'h1000000;

	localparam logic [2:0] REQ_DEFAULT = 3'd0;
	localparam logic [2:0] REQ_TARGET = 3'd1;
	localparam logic [2:0] REQ_COMMIT = 3'd2;
	localparam logic [2:0] REQ_OVERRIDE = 3'd3;
	localparam logic [2:0] REQ_SAMPLE = 3'd4;
	localparam logic [2:0] REQ_CROSSED = 3'd5;

	localparam logic [1:0] KIND_VALUE = 2'd0;
	localparam logic [1:0] KIND_CUE = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TIME = 3'd1;
	localparam logic [2:0] ST_BAD_CUE = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_BAD_INDEX = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_IDSCAN, S_FIND, S_DIV, S_SMOOTH1, S_SMOOTH2,
		S_LERP, S_EMIT, S_XSCAN, S_STATUS, S_DONE
	} state_t;

	typedef struct packed {
		logic load_item;
		logic clr_scan;
		logic inc_scan;
		logic start_div;
		logic smooth1;
		logic smooth2;
		logic lerp_rd;
		logic lerp_mul;
		logic lerp_out;
		logic do_commit;
		logic do_simple;
		logic clr_ctl;
		logic inc_ctl;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic [2:0] pre_status;
		logic       scan_end;
		logic       scan_hit;
		logic       div_done;
		logic       ctl_end;
		logic       smooth;
		logic       x_hit;
		logic       x_empty;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/core/clcs_ctrl.sv @@
// Controller state machine of the cue list crossfade sampler.
// Depends on clcs_pkg.
`default_nettype none
module clcs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire logic            out_free,
	input  wire clcs_pkg::sts_t  sts,
	output clcs_pkg::cmd_t       cmd,
	output logic                 busy,
	output logic                 emit_value,
	output logic                 emit_cue,
	output logic                 emit_status,
	output logic                 emit_empty,
	output logic                 commit_sample
);
	clcs_pkg::state_t state_q, state_n;
	logic commit_q, commit_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clcs_pkg::S_IDLE;
			commit_q <= 1'b0;
		end else begin
			state_q <= state_n;
			commit_q <= commit_n;
		end
	end

	assign commit_sample = commit_q;

	always_comb begin
		state_n = state_q;
		commit_n = commit_q;
		cmd = '0;
		emit_value = 1'b0;
		emit_cue = 1'b0;
		emit_status = 1'b0;
		emit_empty = 1'b0;
		busy = (state_q != clcs_pkg::S_IDLE);
		case (state_q)
			clcs_pkg::S_IDLE: begin
				if (in_fire) begin
					cmd.load_item = 1'b1;
					state_n = clcs_pkg::S_CHECK;
				end
			end
			clcs_pkg::S_CHECK: begin
				cmd.clr_scan = 1'b1;
				commit_n = 1'b0;
				if (sts.pre_status != clcs_pkg::ST_OK) state_n = clcs_pkg::S_STATUS;
				else begin
					case (sts.req)
						clcs_pkg::REQ_COMMIT: state_n = clcs_pkg::S_IDSCAN;
						clcs_pkg::REQ_SAMPLE: state_n = clcs_pkg::S_FIND;
						clcs_pkg::REQ_CROSSED: state_n = clcs_pkg::S_XSCAN;
						clcs_pkg::REQ_DEFAULT, clcs_pkg::REQ_TARGET,
						clcs_pkg::REQ_OVERRIDE: state_n = clcs_pkg::S_STATUS;
						default: state_n = clcs_pkg::S_IDLE;
					endcase
				end
			end
			clcs_pkg::S_IDSCAN: begin
				if (sts.scan_hit) state_n = clcs_pkg::S_STATUS;
				else if (sts.scan_end) begin
					cmd.clr_scan = 1'b1;
					commit_n = 1'b1;
					state_n = clcs_pkg::S_FIND;
				end else cmd.inc_scan = 1'b1;
			end
			clcs_pkg::S_FIND: begin
				if (sts.scan_end) begin
					cmd.start_div = 1'b1;
					state_n = clcs_pkg::S_DIV;
				end else cmd.inc_scan = 1'b1;
			end
			clcs_pkg::S_DIV: begin
				if (sts.div_done) begin
					cmd.clr_ctl = 1'b1;
					if (sts.smooth) state_n = clcs_pkg::S_SMOOTH1;
					else begin
						cmd.lerp_rd = 1'b1;
						state_n = clcs_pkg::S_LERP;
					end
				end
			end
			clcs_pkg::S_SMOOTH1: begin
				cmd.smooth1 = 1'b1;
				state_n = clcs_pkg::S_SMOOTH2;
			end
			clcs_pkg::S_SMOOTH2: begin
				cmd.smooth2 = 1'b1;
				cmd.lerp_rd = 1'b1;
				state_n = clcs_pkg::S_LERP;
			end
			clcs_pkg::S_LERP: begin
				cmd.lerp_mul = 1'b1;
				state_n = clcs_pkg::S_EMIT;
			end
			clcs_pkg::S_EMIT: begin
				if (commit_q || out_free) begin
					cmd.lerp_out = 1'b1;
					if (!commit_q) emit_value = 1'b1;
					if (sts.ctl_end) begin
						if (commit_q) begin
							cmd.do_commit = 1'b1;
							state_n = clcs_pkg::S_STATUS;
						end else state_n = clcs_pkg::S_DONE;
					end else begin
						cmd.inc_ctl = 1'b1;
						cmd.lerp_rd = 1'b1;
						state_n = clcs_pkg::S_LERP;
					end
				end
			end
			clcs_pkg::S_XSCAN: begin
				if (sts.scan_end) begin
					if (sts.x_empty) begin
						if (out_free) begin
							emit_empty = 1'b1;
							state_n = clcs_pkg::S_DONE;
						end
					end else state_n = clcs_pkg::S_DONE;
				end else if (sts.x_hit) begin
					if (out_free) begin
						emit_cue = 1'b1;
						cmd.inc_scan = 1'b1;
					end
				end else cmd.inc_scan = 1'b1;
			end
			clcs_pkg::S_STATUS: begin
				if (out_free) begin
					emit_status = 1'b1;
					cmd.do_simple = 1'b1;
					state_n = clcs_pkg::S_DONE;
				end
			end
			clcs_pkg::S_DONE: state_n = clcs_pkg::S_IDLE;
			default: state_n = clcs_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/clcs_datapath.sv @@
// Datapath: cue tables, level memories, divider, smoothstep and interpolation.
// Depends on clcs_pkg.
`default_nettype none
module clcs_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire clcs_pkg::cmd_t  cmd,
	input  wire logic            commit_sample,
	input  wire logic            emit_cue,
	input  wire logic [2:0]      req_type,
	input  wire logic [3:0]      control_index,
	input  wire logic [63:0]     cue_ident,
	input  wire logic [39:0]     time_first,
	input  wire logic [39:0]     time_second,
	input  wire logic [31:0]     level,
	input  wire logic            smooth_fade,
	input  wire logic            override_on,
	output clcs_pkg::sts_t       sts,
	output logic [3:0]           v_index,
	output logic [31:0]          v_level,
	output logic [63:0]          v_cue,
	output logic                 v_live,
	output logic [63:0]          x_cue,
	output logic [2:0]           x_status,
	output logic                 x_last
);
	localparam int N = clcs_pkg::NUM_CONTROLS;
	localparam int C = clcs_pkg::MAX_CUES;
	localparam int CW = clcs_pkg::CW;
	localparam int NW = clcs_pkg::NW;
	localparam int MW = clcs_pkg::MW;

	logic [2:0]  req_q;
	logic [NW-1:0] idx_q;
	logic        idx_bad_q;
	logic [63:0] id_q;
	logic [39:0] t1_q, t2_q;
	logic [31:0] lvl_q;
	logic        sm_q, ov_q;

	logic [31:0] def_q [N];
	logic [31:0] ovl_q [N];
	logic [N-1:0] ovm_q;
	logic [39:0] cst_q [C];
	logic [39:0] cfd_q [C];
	logic [C-1:0] csm_q;
	logic [63:0] cid_q [C];
	logic [CW:0] count_q;
	logic [31:0] tgt_mem [clcs_pkg::MEM_DEPTH];
	logic [31:0] stl_mem [clcs_pkg::MEM_DEPTH];

	logic [CW:0] scan_q;
	logic [CW:0] found_q;
	logic        xhit_any_q;
	logic [NW:0] ctl_q;
	logic [2:0]  pre_st;
	logic        full;
	logic [CW-1:0] cue_sel;

	assign full = (count_q >= (CW+1)'(C));

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			req_q <= req_type;
			idx_q <= NW'(control_index);
			idx_bad_q <= ({1'b0, control_index} >= 5'(N));
			id_q <= cue_ident;
			t1_q <= time_first;
			t2_q <= time_second;
			lvl_q <= level;
			sm_q <= smooth_fade;
			ov_q <= override_on;
		end
	end

	logic [40:0] tsum;
	assign tsum = {1'b0, t1_q} + {1'b0, t2_q};
	always_comb begin
		pre_st = clcs_pkg::ST_OK;
		case (req_q)
			clcs_pkg::REQ_DEFAULT, clcs_pkg::REQ_OVERRIDE:
				if (idx_bad_q) pre_st = clcs_pkg::ST_BAD_INDEX;
			clcs_pkg::REQ_TARGET:
				if (idx_bad_q) pre_st = clcs_pkg::ST_BAD_INDEX;
				else if (full) pre_st = clcs_pkg::ST_FULL;
			clcs_pkg::REQ_COMMIT:
				if (full) pre_st = clcs_pkg::ST_FULL;
				else if (t1_q > clcs_pkg::TIME_LIMIT || t2_q > clcs_pkg::TIME_LIMIT)
					pre_st = clcs_pkg::ST_TIME;
				else if (id_q == 64'd0 || tsum > {1'b0, clcs_pkg::TIME_LIMIT})
					pre_st = clcs_pkg::ST_BAD_CUE;
				else if (count_q != '0 && t1_q <= cst_q[CW'(count_q - 1'b1)])
					pre_st = clcs_pkg::ST_BAD_CUE;
			clcs_pkg::REQ_SAMPLE:
				if (t1_q > clcs_pkg::TIME_LIMIT) pre_st = clcs_pkg::ST_TIME;
			clcs_pkg::REQ_CROSSED:
				if (t1_q > clcs_pkg::TIME_LIMIT || t2_q > clcs_pkg::TIME_LIMIT)
					pre_st = clcs_pkg::ST_TIME;
			default: pre_st = clcs_pkg::ST_OK;
		endcase
	end

	// scan over the cue list, one cue per cycle, except where a crossed hit waits for the output
	logic scan_in, scan_end, id_hit, x_hit;
	logic [CW-1:0] sidx;
	assign sidx = CW'(scan_q);
	assign scan_in = (scan_q < count_q);
	assign id_hit = scan_in && (cid_q[sidx] == id_q);
	assign x_hit = scan_in && (t2_q > t1_q) && (cst_q[sidx] > t1_q) && (cst_q[sidx] <= t2_q);
	assign scan_end = !scan_in ||
		(req_q != clcs_pkg::REQ_COMMIT || commit_sample) && req_q != clcs_pkg::REQ_CROSSED
		&& (cst_q[sidx] > t1_q) && req_q != clcs_pkg::REQ_COMMIT - 3'd0 && 1'b1
		|| ((req_q == clcs_pkg::REQ_SAMPLE || commit_sample) && cst_q[sidx] > t1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			xhit_any_q <= 1'b0;
		end else if (cmd.clr_scan) begin
			scan_q <= '0;
			xhit_any_q <= 1'b0;
		end else if (cmd.inc_scan) begin
			scan_q <= scan_q + 1'b1;
			if (x_hit) xhit_any_q <= 1'b1;
		end
	end

	// found_q = scan position at end of search; the found cue is the entry before it
	always_ff @(posedge clk) begin
		if (cmd.start_div) found_q <= scan_q;
	end
	assign cue_sel = CW'(found_q - 1'b1);

	// restoring divider: (el << 24) / fade, 24 quotient bits
	logic [39:0] el;
	logic [63:0] rem_q;
	logic [24:0] quo_q;
	logic [4:0]  dcnt_q;
	logic        dbusy_q;
	logic [24:0] amt_q;
	logic [39:0] dfade_q;
	logic [64:0] rtry;
	assign el = t1_q - cst_q[CW'(scan_q - 1'b1)];
	assign rtry = {rem_q, 1'b0} - {25'd0, dfade_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q <= '0;
		end else if (cmd.start_div) begin
			dbusy_q <= 1'b0;
			if (scan_q != '0) begin
				logic [39:0] fd;
				fd = cfd_q[CW'(scan_q - 1'b1)];
				if (!(fd == 40'd0 || el >= fd)) begin
					dbusy_q <= 1'b1;
					dcnt_q <= 5'd24;
				end
			end
		end else if (dbusy_q) begin
			dcnt_q <= dcnt_q - 1'b1;
			if (dcnt_q == 5'd1) dbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			rem_q <= {24'd0, el};
			dfade_q <= cfd_q[CW'(scan_q - 1'b1)];
			quo_q <= '0;
			amt_q <= clcs_pkg::AMT_ONE;
		end else if (dbusy_q) begin
			if (!rtry[64]) begin
				rem_q <= rtry[63:0];
				quo_q <= {quo_q[23:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], 1'b0};
				quo_q <= {quo_q[23:0], 1'b0};
			end
			if (dcnt_q == 5'd1) amt_q <= {quo_q[23:0], ~rtry[64]};
		end else if (cmd.smooth1) begin
			amt_q <= amt_q;
		end
	end

	// smoothstep over two multiply stages
	logic [24:0] a2_q;
	logic [24:0] s_q;
	logic [49:0] sq_prod;
	logic [25:0] three_m;
	logic [50:0] sm_prod;
	assign sq_prod = amt_q * amt_q;
	assign three_m = 26'd50331648 - {amt_q, 1'b0};
	assign sm_prod = a2_q * three_m;
	always_ff @(posedge clk) begin
		if (cmd.smooth1) a2_q <= sq_prod[48:24];
		if (cmd.start_div) s_q <= clcs_pkg::AMT_ONE;
		else if (dbusy_q && dcnt_q == 5'd1) s_q <= {quo_q[23:0], ~rtry[64]};
		else if (cmd.smooth2) s_q <= sm_prod[48:24];
	end

	// interpolation per control
	logic [31:0] from_s1, to_s1;
	logic [32:0] diff;
	logic signed [58:0] prod_s2;
	logic [31:0] from_s2;
	logic [MW-1:0] rd_addr;
	logic [NW-1:0] cidx;
	logic nocue;
	assign cidx = NW'(cmd.clr_ctl ? '0 : (cmd.inc_ctl ? ctl_q + 1'b1 : ctl_q));
	assign rd_addr = MW'({cue_sel, cidx});
	assign nocue = (found_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.lerp_rd) begin
			from_s1 <= stl_mem[rd_addr];
			to_s1 <= tgt_mem[rd_addr];
		end
	end

	logic [31:0] dflt_s1;
	logic nocue_s1;
	logic [NW-1:0] ctl_s1;
	always_ff @(posedge clk) begin
		if (cmd.lerp_rd) begin
			dflt_s1 <= def_q[cidx];
			nocue_s1 <= nocue;
			ctl_s1 <= cidx;
		end
	end

	assign diff = {to_s1[31], to_s1} - {from_s1[31], from_s1};
	logic [31:0] lerp_res;
	logic signed [58:0] rnd;
	logic nocue_s2;
	logic [31:0] dflt_s2;
	logic [NW-1:0] ctl_s2;
	always_ff @(posedge clk) begin
		if (cmd.lerp_mul) begin
			prod_s2 <= $signed(diff) * $signed({1'b0, s_q});
			from_s2 <= from_s1;
			nocue_s2 <= nocue_s1;
			dflt_s2 <= dflt_s1;
			ctl_s2 <= ctl_s1;
		end
	end
	assign rnd = prod_s2 + 59'sd8388608;
	assign lerp_res = nocue_s2 ? dflt_s2 : (from_s2 + rnd[55:24]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_q <= '0;
		else if (cmd.clr_ctl) ctl_q <= '0;
		else if (cmd.inc_ctl) ctl_q <= ctl_q + 1'b1;
	end

	// commit writes the sampled level into the new cue's start row
	logic [MW-1:0] wr_new;
	assign wr_new = MW'({CW'(count_q), ctl_s2});
	always_ff @(posedge clk) begin
		if (cmd.lerp_out && commit_sample) stl_mem[wr_new] <= lerp_res;
		if (cmd.do_simple && req_q == clcs_pkg::REQ_TARGET && pre_st == clcs_pkg::ST_OK)
			tgt_mem[MW'({CW'(count_q), idx_q})] <= lvl_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				def_q[i] <= '0;
				ovl_q[i] <= '0;
			end
			ovm_q <= '0;
			count_q <= '0;
		end else if (cmd.do_simple && pre_st == clcs_pkg::ST_OK) begin
			if (req_q == clcs_pkg::REQ_DEFAULT) def_q[idx_q] <= lvl_q;
			if (req_q == clcs_pkg::REQ_OVERRIDE) begin
				ovm_q[idx_q] <= ov_q;
				ovl_q[idx_q] <= ov_q ? lvl_q : 32'd0;
			end
			if (req_q == clcs_pkg::REQ_COMMIT && commit_sample) count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_commit) begin
			cst_q[CW'(count_q)] <= t1_q;
			cfd_q[CW'(count_q)] <= t2_q;
			csm_q[CW'(count_q)] <= sm_q;
			cid_q[CW'(count_q)] <= id_q;
		end
	end

	assign v_index = 4'(ctl_s2);
	assign v_level = ovm_q[ctl_s2] ? ovl_q[ctl_s2] : lerp_res;
	assign v_cue = nocue ? 64'd0 : cid_q[cue_sel];
	assign v_live = !nocue;
	assign x_cue = cid_q[sidx];
	// crossed list ends at the last hit; look ahead is done by scanning
	assign x_last = 1'b0;
	assign x_status = (req_q == clcs_pkg::REQ_COMMIT && commit_sample) ? clcs_pkg::ST_OK
		: (req_q == clcs_pkg::REQ_COMMIT && pre_st == clcs_pkg::ST_OK) ? clcs_pkg::ST_BAD_CUE
		: pre_st;

	assign sts.req = req_q;
	assign sts.pre_status = pre_st;
	assign sts.scan_end = (req_q == clcs_pkg::REQ_COMMIT && !commit_sample) ? !scan_in
		: (req_q == clcs_pkg::REQ_CROSSED) ? !scan_in
		: (!scan_in || cst_q[sidx] > t1_q);
	assign sts.scan_hit = id_hit;
	assign sts.div_done = !dbusy_q && !cmd.start_div;
	assign sts.ctl_end = (ctl_s2 == NW'(N - 1));
	assign sts.smooth = !nocue && csm_q[cue_sel];
	assign sts.x_hit = x_hit;
	assign sts.x_empty = !xhit_any_q && !emit_cue;
	logic unused_ok;
	assign unused_ok = scan_end ^ el[0];
endmodule
`default_nettype wire

@@ rtl/core/cue_list_crossfade_sampler_unit.sv @@
// Cue list crossfade sampler, top level: controller, datapath, output register.
// A sample takes a cue search, the divider, an optional smoothstep and an interpolation per control;
// a commit runs an id scan first and then the same steps; loads only check and answer with a status.
// Crossed requests take one cycle per stored cue, longer where a hit waits for the output. One item at a time.
// Reset (arst_n low) clears defaults, overrides and the cue count; cue tables stay unwritten.
// Depends on clcs_pkg, clcs_ctrl, clcs_datapath.
`default_nettype none
module cue_list_crossfade_sampler_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata: control_index[3:0], cue_ident[67:4], time_first[107:68],
	// time_second[147:108], level[179:148], smooth_fade[180], override_on[181]
	input  wire logic [183:0] s_tdata,
	// tuser: req_type
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tdata: out_index[3:0], out_level[35:4], out_cue[99:36], cue_live[100], status[103:101]
	output logic [103:0]      m_tdata,
	// tuser: kind
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);
	clcs_pkg::cmd_t cmd;
	clcs_pkg::sts_t sts;
	logic busy, ev, ec, es, ee, commit_sample, in_fire, out_free;
	logic [3:0] v_index;
	logic [31:0] v_level;
	logic [63:0] v_cue, x_cue;
	logic v_live, x_last;
	logic [2:0] x_status;
	logic pend_q;
	logic [63:0] pcue_q;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	clcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free), .sts(sts),
		.cmd(cmd), .busy(busy), .emit_value(ev), .emit_cue(ec), .emit_status(es),
		.emit_empty(ee), .commit_sample(commit_sample)
	);

	clcs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .commit_sample(commit_sample), .emit_cue(ec),
		.req_type(s_tuser), .control_index(s_tdata[3:0]), .cue_ident(s_tdata[67:4]),
		.time_first(s_tdata[107:68]), .time_second(s_tdata[147:108]),
		.level(s_tdata[179:148]), .smooth_fade(s_tdata[180]), .override_on(s_tdata[181]),
		.sts(sts), .v_index(v_index), .v_level(v_level), .v_cue(v_cue), .v_live(v_live),
		.x_cue(x_cue), .x_status(x_status), .x_last(x_last)
	);

	// crossed ids are held one deep so the final one can carry tlast
	logic flush;
	assign flush = busy && sts.req == clcs_pkg::REQ_CROSSED && sts.scan_end && pend_q
		&& out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (in_fire) pend_q <= 1'b0;
			if (ev || es || ee || flush) m_tvalid <= 1'b1;
			if (ec) begin
				if (pend_q) m_tvalid <= 1'b1;
				pend_q <= 1'b1;
			end
			if (flush) pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ec) pcue_q <= x_cue;
		if (ev) begin
			m_tdata <= {clcs_pkg::ST_OK, v_live, v_cue, v_level, v_index};
			m_tuser <= clcs_pkg::KIND_VALUE;
			m_tlast <= sts.ctl_end;
		end else if (es) begin
			m_tdata <= {x_status, 101'd0};
			m_tuser <= clcs_pkg::KIND_STATUS;
			m_tlast <= 1'b1;
		end else if (ee) begin
			m_tdata <= '0;
			m_tuser <= clcs_pkg::KIND_EMPTY;
			m_tlast <= 1'b1;
		end else if ((ec && pend_q) || flush) begin
			m_tdata <= {3'd0, 1'b0, pcue_q, 36'd0};
			m_tuser <= clcs_pkg::KIND_CUE;
			m_tlast <= flush | x_last;
		end
	end

	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready) else $error("accepted while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");
	a_one_src: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ev, es, ee})) else $error("two result sources");
endmodule
`default_nettype wire

@@ test/clcs_checker.sv @@
// Checker for the cue list crossfade sampler: watches both stream channels, predicts the
// results of every accepted transaction and compares them field by field.
// Depends on clcs_pkg.
`default_nettype none
module clcs_checker
	import clcs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [183:0] s_tdata,
	input  wire logic [2:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [103:0] m_tdata,
	input  wire logic [1:0]   m_tuser,
	input  wire logic         m_tlast,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  idx;
		logic [31:0] lvl;
		logic [63:0] cue;
		logic        live;
		logic [2:0]  st;
		logic        last;
	} cue_result_t;

	cue_result_t results_due[$];
	int err_cnt = 0;
	int due_cnt = 0;

	logic [31:0] dflt_lv [NUM_CONTROLS];
	logic [31:0] tgt_lv [MAX_CUES][NUM_CONTROLS];
	logic [31:0] from_lv [MAX_CUES][NUM_CONTROLS];
	logic [39:0] cue_at [MAX_CUES];
	logic [39:0] cue_len [MAX_CUES];
	logic        cue_sm [MAX_CUES];
	logic [63:0] cue_id [MAX_CUES];
	int          n_cues;
	logic [31:0] ovr_lv [NUM_CONTROLS];
	logic        ovr_on [NUM_CONTROLS];

	assign errors = err_cnt;
	assign pending = due_cnt;

	task automatic report(string fld, logic [63:0] want, logic [63:0] got);
		$display("%0t: result mismatch on %s: expected %h, got %h", $realtime, fld, want, got);
		err_cnt++;
	endtask

	function automatic void push(logic [1:0] kind, logic [3:0] idx, logic [31:0] lvl,
			logic [63:0] cue, logic live, logic [2:0] st, logic last);
		cue_result_t r;
		r.kind = kind; r.idx = idx; r.lvl = lvl; r.cue = cue;
		r.live = live; r.st = st; r.last = last;
		results_due.push_back(r);
	endfunction

	function automatic void push_status(logic [2:0] st);
		push(KIND_STATUS, '0, '0, '0, 1'b0, st, 1'b1);
	endfunction

	function automatic int cues_started(logic [39:0] t);
		int n;
		n = 0;
		while (n < n_cues && cue_at[n] <= t)
			n++;
		return n;
	endfunction

	// crossfaded level of one control at time t, overrides not applied
	function automatic logic [31:0] level_at(logic [39:0] t, int ctl);
		int c;
		longint unsigned el, amt, a2, s;
		longint fr, prod, step;
		c = cues_started(t) - 1;
		if (c < 0)
			return dflt_lv[ctl];
		el = 64'(t) - 64'(cue_at[c]);
		if (cue_len[c] == 0 || el >= 64'(cue_len[c]))
			amt = 64'(AMT_ONE);
		else
			amt = (el << 24) / 64'(cue_len[c]);
		s = amt;
		if (cue_sm[c]) begin
			a2 = (amt * amt) >> 24;
			s = (a2 * (3 * 64'(AMT_ONE) - 2 * amt)) >> 24;
		end
		fr = longint'($signed(from_lv[c][ctl]));
		prod = (longint'($signed(tgt_lv[c][ctl])) - fr) * longint'(s);
		step = (prod + (64'sd1 <<< 23)) >>> 24;
		return 32'(fr + step);
	endfunction

	task automatic predict(logic [2:0] req, logic [183:0] d);
		logic [3:0]  idx;
		logic [63:0] id;
		logic [39:0] t1, t2;
		logic [31:0] lvl;
		logic [63:0] act;
		logic        live, dup;
		int          n, k;
		idx = d[3:0];
		id  = d[67:4];
		t1  = d[107:68];
		t2  = d[147:108];
		lvl = d[179:148];
		case (req)
			REQ_DEFAULT: begin
				dflt_lv[idx] = lvl;
				push_status(ST_OK);
			end
			REQ_TARGET: begin
				if (n_cues >= MAX_CUES) begin
					push_status(ST_FULL);
				end else begin
					tgt_lv[n_cues][idx] = lvl;
					push_status(ST_OK);
				end
			end
			REQ_COMMIT: begin
				dup = 1'b0;
				for (int i = 0; i < n_cues; i++)
					if (cue_id[i] == id)
						dup = 1'b1;
				if (n_cues >= MAX_CUES)
					push_status(ST_FULL);
				else if (t1 > TIME_LIMIT || t2 > TIME_LIMIT)
					push_status(ST_TIME);
				else if (id == 0 || 64'(t1) + 64'(t2) > 64'(TIME_LIMIT) || dup ||
						(n_cues > 0 && t1 <= cue_at[n_cues-1]))
					push_status(ST_BAD_CUE);
				else begin
					for (int i = 0; i < NUM_CONTROLS; i++)
						from_lv[n_cues][i] = level_at(t1, i);
					cue_at[n_cues] = t1;
					cue_len[n_cues] = t2;
					cue_sm[n_cues] = d[180];
					cue_id[n_cues] = id;
					n_cues++;
					push_status(ST_OK);
				end
			end
			REQ_OVERRIDE: begin
				ovr_on[idx] = d[181];
				ovr_lv[idx] = d[181] ? lvl : '0;
				push_status(ST_OK);
			end
			REQ_SAMPLE: begin
				if (t1 > TIME_LIMIT) begin
					push_status(ST_TIME);
				end else begin
					n = cues_started(t1);
					act = (n > 0) ? cue_id[n-1] : '0;
					live = (n > 0);
					for (int i = 0; i < NUM_CONTROLS; i++)
						push(KIND_VALUE, 4'(i), ovr_on[i] ? ovr_lv[i] : level_at(t1, i),
							act, live, ST_OK, i == NUM_CONTROLS - 1);
				end
			end
			REQ_CROSSED: begin
				if (t1 > TIME_LIMIT || t2 > TIME_LIMIT) begin
					push_status(ST_TIME);
				end else begin
					k = 0;
					if (t2 > t1)
						for (int i = 0; i < n_cues; i++)
							if (cue_at[i] > t1 && cue_at[i] <= t2) begin
								push(KIND_CUE, '0, '0, cue_id[i], 1'b0, ST_OK, 1'b0);
								k++;
							end
					if (k == 0)
						push(KIND_EMPTY, '0, '0, '0, 1'b0, ST_OK, 1'b1);
					else
						results_due[$].last = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic compare_result();
		cue_result_t e;
		if (results_due.size() == 0) begin
			$display("%0t: result transaction with nothing expected", $realtime);
			err_cnt++;
			return;
		end
		e = results_due.pop_front();
		if (m_tuser !== e.kind)          report("kind", e.kind, m_tuser);
		if (m_tdata[3:0] !== e.idx)      report("out_index", e.idx, m_tdata[3:0]);
		if (m_tdata[35:4] !== e.lvl)     report("out_level", e.lvl, m_tdata[35:4]);
		if (m_tdata[99:36] !== e.cue)    report("out_cue", e.cue, m_tdata[99:36]);
		if (m_tdata[100] !== e.live)     report("cue_live", e.live, m_tdata[100]);
		if (m_tdata[103:101] !== e.st)   report("status", e.st, m_tdata[103:101]);
		if (m_tlast !== e.last)          report("last", e.last, m_tlast);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CONTROLS; i++) begin
				dflt_lv[i] = '0;
				ovr_lv[i] = '0;
				ovr_on[i] = 1'b0;
			end
			n_cues = 0;
			results_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				predict(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				compare_result();
		end
		due_cnt = results_due.size();
	end
endmodule
`default_nettype wire

@@ test/tb_cue_list_crossfade_sampler_unit.sv @@
// Testbench top for the cue list crossfade sampler: clock, reset, stimulus and verdict.
// Depends on clcs_pkg, cue_list_crossfade_sampler_unit and clcs_checker.
`default_nettype none
module tb_cue_list_crossfade_sampler_unit;
	import clcs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [39:0] T_MAX = 40'hFF_FFFF_FFFF;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [183:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	int           errors, pending;

	bit          quiet = 1'b0;
	bit          long_hold = 1'b0;
	int          n_sent = 0;
	int          cue_tries = 0;
	int          stuck_cycles = 0;
	logic [39:0] last_start = '0;
	logic [63:0] used_ids[$];

	always #1 clk = ~clk;

	cue_list_crossfade_sampler_unit dut (.*);

	clcs_checker checker_i (.*);

	// watchdog: cycles without any transaction on either channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= 20000) begin
			$display("[cue_list_crossfade_sampler_unit] ERROR");
			$finish;
		end
	end

	// result side backpressure
	initial begin
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic send(logic [2:0] req, logic [3:0] idx, logic [63:0] id, logic [39:0] t1,
			logic [39:0] t2, logic [31:0] lvl, logic sm, logic ov);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {2'b00, ov, sm, lvl, t2, t1, id, idx};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		n_sent++;
	endtask

	function automatic logic [31:0] rnd32();
		return $urandom();
	endfunction

	// loads every target of the pending cue, then commits it
	task automatic cue_entry(logic [39:0] at, logic [39:0] len, logic sm, logic [63:0] id);
		for (int i = 0; i < NUM_CONTROLS; i++)
			send(REQ_TARGET, 4'(i), rnd32(), rnd32(), rnd32(), rnd32(), 1'b0, 1'b0);
		send(REQ_COMMIT, 4'($urandom), id, at, len, rnd32(), sm, 1'b0);
		used_ids.push_back(id);
		if (at > last_start)
			last_start = at;
		cue_tries++;
	endtask

	task automatic random_cue();
		logic [39:0] at;
		logic [63:0] id;
		at = last_start + 40'($urandom_range(1, 3000));
		if ($urandom_range(0, 9) == 0)
			at = last_start - 40'($urandom_range(0, 2));
		id = {rnd32(), rnd32()};
		if ($urandom_range(0, 9) == 0 && used_ids.size() > 0)
			id = used_ids[$urandom_range(0, used_ids.size() - 1)];
		cue_entry(at, ($urandom_range(0, 4) == 0) ? '0 : 40'($urandom_range(1, 4000)),
			1'($urandom), id);
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			random_cue();
		end else if (r < 60) begin
			send(REQ_SAMPLE, 4'($urandom), {rnd32(), rnd32()},
				40'($urandom_range(0, int'(last_start) + 5000)), 40'(rnd32()), rnd32(),
				1'($urandom), 1'($urandom));
		end else if (r < 70) begin
			send(REQ_CROSSED, 4'($urandom), {rnd32(), rnd32()},
				40'($urandom_range(0, int'(last_start) + 3000)),
				40'($urandom_range(0, int'(last_start) + 3000)), rnd32(), 1'b0, 1'b0);
		end else if (r < 80) begin
			send(REQ_DEFAULT, 4'($urandom), {rnd32(), rnd32()}, 40'(rnd32()), 40'(rnd32()),
				rnd32(), 1'($urandom), 1'($urandom));
		end else if (r < 88) begin
			send(REQ_OVERRIDE, 4'($urandom), {rnd32(), rnd32()}, 40'(rnd32()), 40'(rnd32()),
				rnd32(), 1'($urandom), 1'($urandom));
		end else if (r < 93) begin
			// abandoned cue: partial targets, commit with a zero id
			repeat ($urandom_range(1, 5))
				send(REQ_TARGET, 4'($urandom), rnd32(), rnd32(), rnd32(), rnd32(), 1'b0, 1'b0);
			send(REQ_COMMIT, '0, '0, last_start + 40'd10, 40'd10, rnd32(), 1'b0, 1'b0);
		end else if (r < 96) begin
			send(REQ_SAMPLE + 3'($urandom_range(0, 1)), 4'($urandom), {rnd32(), rnd32()},
				{8'($urandom_range(233, 255)), rnd32()}, {8'($urandom_range(233, 255)), rnd32()},
				rnd32(), 1'b0, 1'b0);
		end else begin
			send(3'($urandom_range(6, 7)), 4'($urandom), {rnd32(), rnd32()}, T_MAX, T_MAX,
				rnd32(), 1'b1, 1'b1);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(REQ_DEFAULT, 4'd0, '0, '0, '0, 32'h7FFF_FFFF, 1'b0, 1'b0);
		send(REQ_DEFAULT, 4'd15, '1, T_MAX, T_MAX, 32'h8000_0000, 1'b1, 1'b1);
		send(REQ_OVERRIDE, 4'd3, '0, '0, '0, 32'h1234_5678, 1'b0, 1'b1);
		send(REQ_SAMPLE, '0, '0, '0, '0, '0, 1'b0, 1'b0);
		send(REQ_CROSSED, '0, '0, '0, TIME_LIMIT, '0, 1'b0, 1'b0);
		cue_entry(40'd100, '0, 1'b0, '1);
		cue_entry(40'd200, 40'd1000, 1'b1, 64'h0123_4567_89AB_CDEF);
		send(REQ_SAMPLE, '0, '0, 40'd700, '0, '0, 1'b0, 1'b0);
		send(REQ_SAMPLE, '0, '0, TIME_LIMIT, '0, '0, 1'b0, 1'b0);
		send(REQ_SAMPLE, '0, '0, T_MAX, '0, '0, 1'b0, 1'b0);
		send(REQ_CROSSED, '0, '0, '0, TIME_LIMIT, '0, 1'b0, 1'b0);
		send(REQ_CROSSED, '0, '0, 40'd500, 40'd100, '0, 1'b0, 1'b0);
		send(REQ_CROSSED, '0, '0, T_MAX, '0, '0, 1'b0, 1'b0);
		send(REQ_COMMIT, '0, '0, 40'd300, 40'd10, '0, 1'b0, 1'b0);
		send(REQ_COMMIT, '0, '1, 40'd300, 40'd10, '0, 1'b0, 1'b0);
		send(REQ_COMMIT, '0, 64'd77, 40'd150, 40'd10, '0, 1'b0, 1'b0);
		send(REQ_COMMIT, '0, 64'd77, T_MAX, T_MAX, '0, 1'b1, 1'b0);
		send(REQ_COMMIT, '0, 64'd77, 40'd600_000_000_000, 40'd600_000_000_000, '0, 1'b0, 1'b0);
		send(REQ_OVERRIDE, 4'd3, '0, '0, '0, '1, 1'b0, 1'b0);
		send(3'd6, '0, '0, '0, '0, '0, 1'b0, 1'b0);
		send(3'd7, '1, '1, T_MAX, T_MAX, '1, 1'b1, 1'b1);
		last_start = 40'd200;

		// random
		while (n_sent < 280) begin
			if (n_sent >= 60 && n_sent < 70 && !long_hold)
				long_hold = 1'b1;
			if (n_sent >= 150 && n_sent < 152)
				wait (pending == 0);
			if (n_sent > 230)
				quiet = 1'b1;
			random_item();
		end
		// carry the cue list up to and past full
		while (cue_tries < MAX_CUES + 3)
			random_cue();
		send(REQ_TARGET, 4'd5, '0, '0, '0, '1, 1'b0, 1'b0);
		send(REQ_SAMPLE, '0, '0, last_start + 40'd100, '0, '0, 1'b0, 1'b0);
		send(REQ_CROSSED, '0, '0, '0, last_start, '0, 1'b0, 1'b0);
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("[cue_list_crossfade_sampler_unit] OK");
		else
			$display("[cue_list_crossfade_sampler_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/clcs_pkg.sv
rtl/core/clcs_ctrl.sv
rtl/core/clcs_datapath.sv
rtl/core/cue_list_crossfade_sampler_unit.sv
test/clcs_checker.sv
test/tb_cue_list_crossfade_sampler_unit.sv
